@@ src/rsp_pkg.sv @@
// Shared types and constants for the RESP stream parser.
// No dependencies.
package rsp_pkg;

   localparam int MaxDepth = 16;
   localparam int DepthW = $clog2(MaxDepth + 1);
   localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
   localparam int LenW = 31;

   localparam logic [7:0] ChLf = 8'h0A;
   localparam logic [7:0] ChCr = 8'h0D;
   localparam logic [7:0] ChPlus = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChStar = 8'h2A;
   localparam logic [7:0] ChUnder = 8'h5F;
   localparam logic [7:0] ChComma = 8'h2C;
   localparam logic [LenW-1:0] MaxLenReset = 31'd536870912;
   localparam logic [63:0] HalfLimit = 64'h8000_0000_0000_0000;

   typedef enum logic [3:0] {
      K_BYTE = 4'd0, K_SIMPLE = 4'd1, K_ERROR = 4'd2, K_INT = 4'd3, K_BULK = 4'd4,
      K_NULL = 4'd5, K_ARRAY = 4'd6, K_DOUBLE = 4'd7, K_FAIL = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      E_NONE = 4'd0, E_EOF = 4'd1, E_NOLF = 4'd2, E_CRLF = 4'd3, E_EMPTY = 4'd4,
      E_INT = 4'd5, E_LEN = 4'd6, E_TRUNC = 4'd7, E_NULL = 4'd8, E_TYPE = 4'd9,
      E_DEEP = 4'd10
   } err_type;

   typedef enum logic [2:0] {
      VT_NONE = 3'd0, VT_SIMPLE = 3'd1, VT_ERROR = 3'd2, VT_INT = 3'd3,
      VT_BULK = 3'd4, VT_ARRAY = 3'd5, VT_NULL = 3'd6, VT_DOUBLE = 3'd7
   } vtype_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  data_byte;
      logic [63:0] number;
      logic [4:0]  nesting;
      logic [3:0]  error_code;
      logic        top_done;
      logic        last_of_run;
   } result_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;      // latch input item, run first decision
      logic       pop_start; // begin stack unwind
      logic       pop_step;  // one unwind step
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       needs_pop; // step ended a value, stack unwind required
      logic       pop_done;  // unwind finished
   } stat_type;

   function automatic vtype_type type_of(input logic [7:0] b);
      case (b)
         ChPlus:   return VT_SIMPLE;
         ChMinus:  return VT_ERROR;
         ChColon:  return VT_INT;
         ChDollar: return VT_BULK;
         ChStar:   return VT_ARRAY;
         ChUnder:  return VT_NULL;
         ChComma:  return VT_DOUBLE;
         default:  return VT_NONE;
      endcase
   endfunction

endpackage

@@ src/rsp_if.sv @@
// Valid/ready channel interfaces for the RESP stream parser.
// No dependencies.
interface rsp_in_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_buffer;
   modport source (output valid, in_byte, end_of_buffer, input ready);
   modport sink (input valid, in_byte, end_of_buffer, output ready);
endinterface

interface rsp_out_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [7:0]  data_byte;
   logic [63:0] number;
   logic [4:0]  nesting;
   logic [3:0]  error_code;
   logic        top_done;
   logic        last_of_run;
   modport source (output valid, kind, data_byte, number, nesting, error_code, top_done,
                   last_of_run, input ready);
   modport sink (input valid, kind, data_byte, number, nesting, error_code, top_done,
                 last_of_run, output ready);
endinterface

interface rsp_cfg_if;
   logic        valid;
   logic        ready;
   logic [30:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ src/resp_stream_parser.sv @@
// Top level of the RESP stream parser.
// Depends on rsp_pkg, rsp_if, rsp_ctrl and rsp_datapath.
//
// Usage:
//   req  : one item per transfer, a buffer byte or an end-of-buffer mark.
//   rsp  : parse events (payload bytes, value ends, headers, errors); an
//          item yields zero, one or two events, the last flagged last_of_run.
//   csr  : writes max_length; always ready, write only while idle.
// Flow: an item that yields no event passes through the IDLE and CHECK states;
//   each event is then transferred in OUT0 or OUT1. Ending a value inside arrays
//   walks the count stack (RAM with registered read, read then write), one POPRD
//   and one POP state per level popped. req_ready is low until all events of the
//   item are transferred; a stalled rsp holds the event stable.
// Reset (synchronous) returns to awaiting a type byte at depth 0 and sets
//   max_length to 536870912. Stack contents are not cleared; each entry is
//   written before it is read.
module resp_stream_parser
   import rsp_pkg::*;
(
   input logic clock,
   input logic reset,
   rsp_in_if.sink    req,
   rsp_out_if.source rsp,
   rsp_cfg_if.sink   csr
);
   cmd_type         cmd;
   stat_type        stat;
   result_type      res0, res1, sel;
   logic [1:0]      res_count;
   logic            out_sel;
   logic [LenW-1:0] max_len_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= MaxLenReset;
      else if (csr.valid) max_len_ff <= csr.data;
   end

   rsp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_sel, .res_count, .cmd, .stat
   );

   rsp_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .in_byte(req.in_byte), .end_of_buffer(req.end_of_buffer),
      .max_length(max_len_ff), .res0, .res1, .res_count
   );

   assign sel = out_sel ? res1 : res0;
   assign rsp.kind = sel.kind;
   assign rsp.data_byte = sel.data_byte;
   assign rsp.number = sel.number;
   assign rsp.nesting = sel.nesting;
   assign rsp.error_code = sel.error_code;
   assign rsp.top_done = sel.top_done;
   assign rsp.last_of_run = sel.last_of_run;
endmodule

@@ src/rsp_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module rsp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/rsp_datapath.sv @@
// Datapath of the RESP stream parser: line state, integer decode, stack, results.
// Depends on rsp_pkg and rsp_ram.
module rsp_datapath
   import rsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [7:0]       in_byte,
   input  logic             end_of_buffer,
   input  logic [LenW-1:0]  max_length,
   output result_type       res0,
   output result_type       res1,
   output logic [1:0]       res_count
);
   localparam logic [2:0] PhType = 3'd0, PhLine = 3'd1, PhBody = 3'd2, PhBcr = 3'd3,
                          PhBlf = 3'd4, PhBbad = 3'd5;

   logic [2:0]        phase_ff, phase_in;
   vtype_type         vt_ff, vt_in;
   logic              held_ff, held_in;
   logic [63:0]       acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic [1:0]        dig_ff, dig_in;
   logic              seen_ff, seen_in;
   logic [LenW-1:0]   brem_ff, brem_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic              fin_ff, fin_in;
   logic              err_ff, err_in;
   result_type        r0_ff, r0_in, r1_ff, r1_in;
   logic [1:0]        n_ff, n_in;
   // pending finish: kind/number/nest saved for the unwind
   kind_type          pk_ff, pk_in;
   logic [63:0]       pn_ff, pn_in;
   logic [4:0]        pnest_ff, pnest_in;

   logic              wr_en;
   logic [IdxW-1:0]   wr_addr, rd_addr;
   logic [LenW-1:0]   wr_data, rd_data;
   logic [LenW-1:0]   dec;

   rsp_ram #(.Width(LenW), .Depth(MaxDepth)) u_stack (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // Top of stack is prefetched: read address points at depth-1, except in a non-final unwind step (depth-2).
   assign dec = rd_data - 1'b1;

   always_comb begin
      logic [7:0]  b;
      logic        do_content;
      logic [7:0]  cb;
      logic        do_cr_content;
      logic        finish;
      kind_type    fk;
      logic [63:0] fnum;
      logic [63:0] lim;
      logic        ok;
      logic [63:0] a;
      logic [63:0] prod;
      result_type  ev;

      phase_in = phase_ff; vt_in = vt_ff; held_in = held_ff; acc_in = acc_ff;
      neg_in = neg_ff; dig_in = dig_ff; seen_in = seen_ff; brem_in = brem_ff;
      depth_in = depth_ff; fin_in = fin_ff; err_in = err_ff;
      r0_in = r0_ff; r1_in = r1_ff; n_in = n_ff;
      pk_in = pk_ff; pn_in = pn_ff; pnest_in = pnest_ff;
      stat.needs_pop = 1'b0;
      stat.pop_done = 1'b0;
      wr_en = 1'b0; wr_data = '0;
      wr_addr = depth_ff[IdxW-1:0];
      rd_addr = depth_ff[IdxW-1:0] - 1'b1;
      b = in_byte;
      finish = 1'b0; fk = K_BYTE; fnum = '0;
      do_content = 1'b0; cb = b; do_cr_content = 1'b0;
      lim = '0; ok = 1'b0; a = '0; prod = '0;
      ev = '0;

      if (cmd.load) begin
         n_in = 2'd0;
         r0_in = '0; r1_in = '0;
         if (end_of_buffer) begin
            if (!fin_ff && !err_ff) begin
               r0_in.kind = K_FAIL;
               r0_in.nesting = 5'(depth_ff);
               if (phase_ff == PhType && !held_ff) r0_in.error_code = E_EOF;
               else if (phase_ff == PhType || phase_ff == PhLine) r0_in.error_code = E_NOLF;
               else r0_in.error_code = E_TRUNC;
               n_in = 2'd1;
            end
            phase_in = PhType; vt_in = VT_NONE; held_in = 1'b0; acc_in = '0;
            neg_in = 1'b0; dig_in = '0; seen_in = 1'b0;
            brem_in = '0; depth_in = '0; fin_in = 1'b0; err_in = 1'b0;
         end else if (!fin_ff && !err_ff) begin
            case (phase_ff)
               PhBody: begin
                  r0_in.kind = K_BYTE; r0_in.data_byte = b;
                  r0_in.nesting = 5'(depth_ff);
                  n_in = 2'd1;
                  brem_in = brem_ff - 1'b1;
                  if (brem_in == '0) phase_in = PhBcr;
               end
               PhBcr: phase_in = (b == ChCr) ? PhBlf : PhBbad;
               PhBlf: begin
                  if (b == ChLf) begin
                     finish = 1'b1; fk = K_BULK;
                  end else begin
                     r0_in.kind = K_FAIL; r0_in.error_code = E_CRLF;
                     r0_in.nesting = 5'(depth_ff); n_in = 2'd1; err_in = 1'b1;
                  end
               end
               PhBbad: begin
                  r0_in.kind = K_FAIL; r0_in.error_code = E_CRLF;
                  r0_in.nesting = 5'(depth_ff); n_in = 2'd1; err_in = 1'b1;
               end
               default: begin
                  if (b == ChLf) begin
                     if (!held_ff) begin
                        r0_in.kind = K_FAIL; r0_in.error_code = E_CRLF;
                        r0_in.nesting = 5'(depth_ff); n_in = 2'd1; err_in = 1'b1;
                     end else begin
                        held_in = 1'b0;
                        // end of line
                        if (phase_ff == PhType) begin
                           r0_in.kind = K_FAIL; r0_in.error_code = E_EMPTY;
                           r0_in.nesting = 5'(depth_ff); n_in = 2'd1; err_in = 1'b1;
                        end else begin
                           lim = neg_ff ? HalfLimit : HalfLimit - 1'b1;
                           ok = (dig_ff >= 2'd2) && (acc_ff <= lim);
                           case (vt_ff)
                              VT_SIMPLE: begin finish = 1'b1; fk = K_SIMPLE; end
                              VT_ERROR:  begin finish = 1'b1; fk = K_ERROR; end
                              VT_DOUBLE: begin finish = 1'b1; fk = K_DOUBLE; end
                              VT_NULL: begin
                                 if (seen_ff) begin
                                    r0_in.kind = K_FAIL; r0_in.error_code = E_NULL;
                                    r0_in.nesting = 5'(depth_ff); n_in = 2'd1;
                                    err_in = 1'b1;
                                 end else begin
                                    finish = 1'b1; fk = K_NULL;
                                 end
                              end
                              VT_INT: begin
                                 if (!ok) begin
                                    r0_in.kind = K_FAIL; r0_in.error_code = E_INT;
                                    r0_in.nesting = 5'(depth_ff); n_in = 2'd1;
                                    err_in = 1'b1;
                                 end else begin
                                    finish = 1'b1; fk = K_INT;
                                    fnum = neg_ff ? (64'd0 - acc_ff) : acc_ff;
                                 end
                              end
                              VT_BULK, VT_ARRAY: begin
                                 if (!ok) begin
                                    r0_in.kind = K_FAIL; r0_in.error_code = E_INT;
                                    r0_in.nesting = 5'(depth_ff); n_in = 2'd1;
                                    err_in = 1'b1;
                                 end else if (neg_ff && acc_ff == 64'd1) begin
                                    finish = 1'b1; fk = K_NULL;
                                 end else if ((neg_ff && acc_ff > 64'd1) ||
                                              (!neg_ff && acc_ff >= 64'(max_length))) begin
                                    r0_in.kind = K_FAIL; r0_in.error_code = E_LEN;
                                    r0_in.nesting = 5'(depth_ff); n_in = 2'd1;
                                    err_in = 1'b1;
                                 end else begin
                                    a = neg_ff ? 64'd0 : acc_ff;
                                    if (vt_ff == VT_BULK) begin
                                       phase_in = (a == '0) ? PhBcr : PhBody;
                                       brem_in = a[LenW-1:0];
                                       vt_in = VT_NONE; acc_in = '0; neg_in = 1'b0;
                                       dig_in = '0; seen_in = 1'b0;
                                    end else if (a == '0) begin
                                       finish = 1'b1; fk = K_ARRAY;
                                    end else if (32'(depth_ff) >= 32'(MaxDepth)) begin
                                       r0_in.kind = K_FAIL; r0_in.error_code = E_DEEP;
                                       r0_in.nesting = 5'(depth_ff); n_in = 2'd1;
                                       err_in = 1'b1;
                                    end else begin
                                       r0_in.kind = K_ARRAY; r0_in.number = a;
                                       r0_in.nesting = 5'(depth_ff); n_in = 2'd1;
                                       wr_en = 1'b1; wr_data = a[LenW-1:0];
                                       depth_in = depth_ff + 1'b1;
                                       phase_in = PhType; vt_in = VT_NONE;
                                       acc_in = '0; neg_in = 1'b0; dig_in = '0;
                                       seen_in = 1'b0;
                                    end
                                 end
                              end
                              default: begin
                                 r0_in.kind = K_FAIL; r0_in.error_code = E_TYPE;
                                 r0_in.nesting = 5'(depth_ff); n_in = 2'd1; err_in = 1'b1;
                              end
                           endcase
                        end
                     end
                  end else begin
                     // release a held CR as content, then handle b
                     do_cr_content = held_ff;
                     held_in = (b == ChCr);
                     do_content = (b != ChCr);
                  end
               end
            endcase

            // Content processing: up to two bytes (held CR, then b).
            for (int k = 0; k < 2; k++) begin
               if ((k == 0 && do_cr_content) || (k == 1 && do_content)) begin
                  cb = (k == 0) ? ChCr : b;
                  if (phase_in == PhType) begin
                     vt_in = type_of(cb);
                     phase_in = PhLine;
                  end else begin
                     case (vt_in)
                        VT_SIMPLE, VT_ERROR, VT_DOUBLE: begin
                           ev = '0; ev.kind = K_BYTE; ev.data_byte = cb;
                           ev.nesting = 5'(depth_ff);
                           if (n_in == 2'd0) r0_in = ev; else r1_in = ev;
                           n_in = n_in + 1'b1;
                        end
                        VT_INT, VT_BULK, VT_ARRAY: begin
                           if (dig_in != 2'd3) begin
                              if (dig_in == 2'd0 && cb == ChMinus) begin
                                 neg_in = 1'b1; dig_in = 2'd1;
                              end else if (cb < 8'h30 || cb > 8'h39) begin
                                 if (dig_in != 2'd2) acc_in = '1;
                                 dig_in = 2'd3;
                              end else begin
                                 dig_in = 2'd2;
                                 if (acc_in > HalfLimit / 10) acc_in = '1;
                                 else begin
                                    prod = {acc_in[60:0], 3'b0} + {acc_in[62:0], 1'b0}
                                           + 64'(cb - 8'h30);
                                    acc_in = (prod > HalfLimit) ? '1 : prod;
                                 end
                              end
                           end
                        end
                        VT_NULL: seen_in = 1'b1;
                        default: ;
                     endcase
                  end
               end
            end
         end

         if (finish) begin
            if (depth_ff == '0) begin
               fin_in = 1'b1;
               r0_in.kind = fk; r0_in.number = fnum; r0_in.nesting = '0;
               r0_in.top_done = 1'b1; n_in = 2'd1;
               phase_in = PhType; vt_in = VT_NONE; held_in = 1'b0; acc_in = '0;
               neg_in = 1'b0; dig_in = '0; seen_in = 1'b0;
            end else begin
               stat.needs_pop = 1'b1;
               pk_in = fk; pn_in = fnum; pnest_in = 5'(depth_ff);
            end
         end
         if (n_in != 2'd0) begin
            if (n_in == 2'd1) r0_in.last_of_run = 1'b1;
            else r1_in.last_of_run = 1'b1;
         end
      end else if (cmd.pop_step) begin
         // rd_data holds count at depth-1 (prefetched)
         wr_en = 1'b1;
         wr_addr = depth_ff[IdxW-1:0] - 1'b1;
         wr_data = dec;
         if (dec != '0 || depth_ff == DepthW'(1)) begin
            if (dec == '0) depth_in = '0;
            stat.pop_done = 1'b1;
            fin_in = (dec == '0);
            r0_in = '0;
            r0_in.kind = pk_ff; r0_in.number = pn_ff; r0_in.nesting = pnest_ff;
            r0_in.top_done = (dec == '0);
            r0_in.last_of_run = 1'b1;
            n_in = 2'd1;
            phase_in = PhType; vt_in = VT_NONE; held_in = 1'b0; acc_in = '0;
            neg_in = 1'b0; dig_in = '0; seen_in = 1'b0;
         end else begin
            depth_in = depth_ff - 1'b1;
            rd_addr = depth_ff[IdxW-1:0] - 2'd2;
         end
      end else if (cmd.pop_start) begin
         rd_addr = depth_ff[IdxW-1:0] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhType; vt_ff <= VT_NONE; held_ff <= 1'b0; acc_ff <= '0;
         neg_ff <= 1'b0; dig_ff <= '0; seen_ff <= 1'b0; brem_ff <= '0;
         depth_ff <= '0; fin_ff <= 1'b0; err_ff <= 1'b0; n_ff <= '0;
      end else begin
         phase_ff <= phase_in; vt_ff <= vt_in; held_ff <= held_in; acc_ff <= acc_in;
         neg_ff <= neg_in; dig_ff <= dig_in; seen_ff <= seen_in; brem_ff <= brem_in;
         depth_ff <= depth_in; fin_ff <= fin_in; err_ff <= err_in; n_ff <= n_in;
      end
      r0_ff <= r0_in; r1_ff <= r1_in;
      pk_ff <= pk_in; pn_ff <= pn_in; pnest_ff <= pnest_in;
   end

   assign res0 = r0_ff;
   assign res1 = r1_ff;
   assign res_count = n_ff;
endmodule

@@ src/rsp_ctrl.sv @@
// Controller of the RESP stream parser: input handshake, stack unwind, result drain.
// Depends on rsp_pkg.
module rsp_ctrl
   import rsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output logic       out_sel,
   input  logic [1:0] res_count,
   output cmd_type    cmd,
   input  stat_type   stat
);
   typedef enum logic [2:0] {S_IDLE, S_CHECK, S_POPRD, S_POP, S_OUT0, S_OUT1} state_type;
   state_type state_ff;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT0) || (state_ff == S_OUT1);
   assign out_sel = (state_ff == S_OUT1);
   assign cmd.load = in_valid && in_ready;
   assign cmd.pop_start = (state_ff == S_POPRD);
   assign cmd.pop_step = (state_ff == S_POP);

   logic pend_pop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_pop_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.load) begin
                  state_ff <= S_CHECK;
                  pend_pop_ff <= stat.needs_pop;
               end
            end
            S_CHECK: begin
               if (pend_pop_ff) state_ff <= S_POPRD;
               else if (res_count != 2'd0) state_ff <= S_OUT0;
               else state_ff <= S_IDLE;
            end
            S_POPRD: state_ff <= S_POP;
            S_POP: begin
               // non-final step changes read address: go back to S_POPRD for the registered read data
               if (stat.pop_done) state_ff <= S_OUT0;
               else state_ff <= S_POPRD;
            end
            S_OUT0: begin
               if (out_ready) state_ff <= (res_count == 2'd2) ? S_OUT1 : S_IDLE;
            end
            S_OUT1: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ src/rsp_checker.sv @@
// Port-level checks for the RESP stream parser, bound to the top level.
// Depends on rsp_pkg.
module rsp_checker
   import rsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_kind,
   input logic [3:0]  rsp_error_code,
   input logic        rsp_top_done
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while events pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("event dropped under stall");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == K_FAIL |-> rsp_error_code != E_NONE && !rsp_top_done)
      else $error("bad error event");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("back-to-back accept");
endmodule

bind resp_stream_parser rsp_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_error_code(rsp.error_code), .rsp_top_done(rsp.top_done)
);
